// ----- src/point_in_polygon_ray_parity_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the ray parity block
// Clocked on clk, quiet while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef POINT_IN_POLYGON_RAY_PARITY_MACROS_SVH
`define POINT_IN_POLYGON_RAY_PARITY_MACROS_SVH

// consequent checked in the same cycle
`define PIPR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the next cycle
`define PIPR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/pipr_pkg.sv -----
// ----------------------------------------------------------------------------
// pipr_pkg
// Widths, types and sequencer codes shared by the ray parity block.
// ----------------------------------------------------------------------------
`default_nettype none

package pipr_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int DIFF_W      = COORD_WIDTH + 1;
	localparam int PROD_W      = 2 * DIFF_W;
	localparam int ACC_W       = PROD_W + 1;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]      diff_t;
	typedef logic signed [PROD_W-1:0]      prod_t;
	typedef logic signed [ACC_W-1:0]       acc_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIFF,
		ST_MUL_AB,
		ST_MUL_CD,
		ST_SUB,
		ST_DECIDE,
		ST_EMIT
	} state_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_DIFF,
		OP_MUL_AB,
		OP_MUL_CD,
		OP_SUB
	} mac_op_t;

	typedef struct packed {
		mac_op_t op;
		logic    closing;
		logic    decide;
		logic    emit;
	} seq_ctrl_t;

	function automatic diff_t widen(coord_t v);
		return {v[COORD_WIDTH-1], v};
	endfunction

endpackage

`default_nettype wire

// ----- src/pipr_vtx_if.sv -----
// ----------------------------------------------------------------------------
// pipr_vtx_if
// Vertex channel: query point, one polygon corner and the closing mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface pipr_vtx_if;
	logic             valid;
	logic             ready;
	pipr_pkg::coord_t query_x;
	pipr_pkg::coord_t query_y;
	pipr_pkg::coord_t corner_x;
	pipr_pkg::coord_t corner_y;
	logic             final_corner;

	modport source (
		output valid, query_x, query_y, corner_x, corner_y, final_corner,
		input  ready
	);
	modport sink (
		input  valid, query_x, query_y, corner_x, corner_y, final_corner,
		output ready
	);
endinterface

`default_nettype wire

// ----- src/pipr_res_if.sv -----
// ----------------------------------------------------------------------------
// pipr_res_if
// Result channel: inside flag for one closed polygon.
// ----------------------------------------------------------------------------
`default_nettype none

interface pipr_res_if;
	logic valid;
	logic ready;
	logic inside_res;

	modport source (output valid, inside_res, input ready);
	modport sink (input valid, inside_res, output ready);
endinterface

`default_nettype wire

// ----- src/point_in_polygon_ray_parity.sv -----
// ----------------------------------------------------------------------------
// point_in_polygon_ray_parity
// Point in polygon by crossing parity of a vertical ray.
// ----------------------------------------------------------------------------
// Usage:
//   vtx carries one polygon corner per transfer together with the query point;
//   final_corner marks the corner that closes the polygon. res carries one
//   inside flag per closed polygon.
//   Each edge runs through one shared 17x17 multiplier and a 35-bit
//   accumulator: difference, two products, subtract, decide.
//   The first corner of a polygon leaves ready high.
//   A later corner holds ready low until its edge is decided.
//   The closing corner also tests the closing edge (a lone corner only that
//   one): the result becomes valid and ready returns in the same cycle.
//   The result sits in an output register; while it waits the block takes
//   further corners, and only a second closing corner waits for the
//   receiver to take the first result.
//   arst_n clears the polygon state (no start corner, even parity) and the
//   output valid.
// ----------------------------------------------------------------------------
`default_nettype none

`include "point_in_polygon_ray_parity_macros.svh"

module point_in_polygon_ray_parity (
	input  wire logic clk,
	input  wire logic arst_n,
	pipr_vtx_if.sink  vtx,
	pipr_res_if.source res
);

	pipr_pkg::coord_t px_q, py_q, cur_x_q, cur_y_q;
	pipr_pkg::coord_t start_x_q, start_y_q, prior_x_q, prior_y_q;
	pipr_pkg::coord_t edge_cx, edge_cy, edge_dx, edge_dy;
	logic             last_q, seen_q, parity_q;
	logic             out_valid_q, inside_q;

	logic                vtx_fire, out_free, idle, crosses;
	pipr_pkg::seq_ctrl_t ctrl;

	assign vtx_fire  = vtx.valid && vtx.ready;
	assign out_free  = !out_valid_q || res.ready;
	assign vtx.ready = idle;
	assign res.valid      = out_valid_q;
	assign res.inside_res = inside_q;

	// running edge prior->current, closing edge current->start
	always_comb begin
		edge_cx = ctrl.closing ? cur_x_q   : prior_x_q;
		edge_cy = ctrl.closing ? cur_y_q   : prior_y_q;
		edge_dx = ctrl.closing ? start_x_q : cur_x_q;
		edge_dy = ctrl.closing ? start_y_q : cur_y_q;
	end

	pipr_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.vtx_fire (vtx_fire),
		.final_in (vtx.final_corner),
		.seen     (seen_q),
		.last     (last_q),
		.out_free (out_free),
		.idle     (idle),
		.ctrl     (ctrl)
	);

	pipr_mac u_mac (
		.clk     (clk),
		.op      (ctrl.op),
		.px      (px_q),
		.py      (py_q),
		.cx      (edge_cx),
		.cy      (edge_cy),
		.dx      (edge_dx),
		.dy      (edge_dy),
		.crosses (crosses)
	);

	always_ff @(posedge clk) begin
		if (vtx_fire) begin
			px_q    <= vtx.query_x;
			py_q    <= vtx.query_y;
			cur_x_q <= vtx.corner_x;
			cur_y_q <= vtx.corner_y;
		end
		if (ctrl.emit) begin
			inside_q <= parity_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q      <= 1'b0;
			seen_q      <= 1'b0;
			parity_q    <= 1'b0;
			start_x_q   <= '0;
			start_y_q   <= '0;
			prior_x_q   <= '0;
			prior_y_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (vtx_fire) begin
				last_q <= vtx.final_corner;
				if (!seen_q) begin
					start_x_q <= vtx.corner_x;
					start_y_q <= vtx.corner_y;
					prior_x_q <= vtx.corner_x;
					prior_y_q <= vtx.corner_y;
					seen_q    <= 1'b1;
					parity_q  <= 1'b0;
				end
			end
			if (ctrl.decide) begin
				parity_q  <= parity_q ^ crosses;
				prior_x_q <= cur_x_q;
				prior_y_q <= cur_y_q;
			end
			if (ctrl.emit) begin
				out_valid_q <= 1'b1;
				seen_q      <= 1'b0;
				parity_q    <= 1'b0;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`PIPR_ASSERT_NEXT(a_busy_after_edge, vtx_fire && (seen_q || vtx.final_corner), !vtx.ready, "block took a corner while an edge was in progress")
	`PIPR_ASSERT_NOW(a_emit_on_last, ctrl.emit, last_q && seen_q, "result given for a corner that does not close a polygon")
	`PIPR_ASSERT_NEXT(a_clear_after_emit, ctrl.emit, !seen_q && !parity_q && res.valid, "polygon state not cleared after a result")
	`PIPR_ASSERT_NOW(a_decide_with_start, ctrl.decide, seen_q && !vtx.ready, "edge decided without a start corner")

endmodule

`default_nettype wire

// ----- src/pipr_mac.sv -----
// ----------------------------------------------------------------------------
// pipr_mac
// Shared difference / multiply / accumulate unit and the edge crossing test.
// ----------------------------------------------------------------------------
`default_nettype none

module pipr_mac (
	input  wire logic                clk,
	input  wire pipr_pkg::mac_op_t   op,
	input  wire pipr_pkg::coord_t    px,
	input  wire pipr_pkg::coord_t    py,
	input  wire pipr_pkg::coord_t    cx,
	input  wire pipr_pkg::coord_t    cy,
	input  wire pipr_pkg::coord_t    dx,
	input  wire pipr_pkg::coord_t    dy,
	output logic                     crosses
);

	// a = cx-px, b = dy-py, c = cy-py, d = dx-px, e = dx-cx
	pipr_pkg::diff_t a_q, b_q, c_q, d_q, e_q;
	pipr_pkg::prod_t prod_q;
	pipr_pkg::acc_t  acc_q;

	pipr_pkg::diff_t mul_x, mul_y;
	pipr_pkg::prod_t product;

	logic a_zero, d_zero, e_zero, acc_zero;
	logic same_side;

	always_comb begin
		mul_x   = (op == pipr_pkg::OP_MUL_CD) ? c_q : a_q;
		mul_y   = (op == pipr_pkg::OP_MUL_CD) ? d_q : b_q;
		product = mul_x * mul_y;
	end

	always_ff @(posedge clk) begin
		case (op)
			pipr_pkg::OP_DIFF: begin
				a_q <= pipr_pkg::widen(cx) - pipr_pkg::widen(px);
				b_q <= pipr_pkg::widen(dy) - pipr_pkg::widen(py);
				c_q <= pipr_pkg::widen(cy) - pipr_pkg::widen(py);
				d_q <= pipr_pkg::widen(dx) - pipr_pkg::widen(px);
				e_q <= pipr_pkg::widen(dx) - pipr_pkg::widen(cx);
			end
			pipr_pkg::OP_MUL_AB: begin
				prod_q <= product;
			end
			pipr_pkg::OP_MUL_CD: begin
				prod_q <= product;
				acc_q  <= pipr_pkg::ACC_W'(prod_q);
			end
			pipr_pkg::OP_SUB: begin
				acc_q <= acc_q - pipr_pkg::ACC_W'(prod_q);
			end
			default: begin
			end
		endcase
	end

	// valid while the sequencer sits in its decide step
	always_comb begin
		a_zero    = (a_q == '0);
		d_zero    = (d_q == '0);
		e_zero    = (e_q == '0);
		acc_zero  = (acc_q == '0);
		same_side = !a_zero && (a_q[pipr_pkg::DIFF_W-1] == d_q[pipr_pkg::DIFF_W-1]);
		crosses   = !e_zero && !d_zero && !same_side &&
			(acc_zero || (acc_q[pipr_pkg::ACC_W-1] != e_q[pipr_pkg::DIFF_W-1]));
	end

endmodule

`default_nettype wire

// ----- src/pipr_seq.sv -----
// ----------------------------------------------------------------------------
// pipr_seq
// Sequencer: steps the shared unit through each edge as its vertex arrives.
// ----------------------------------------------------------------------------
`default_nettype none

module pipr_seq (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  vtx_fire,
	input  wire logic                  final_in,
	input  wire logic                  seen,
	input  wire logic                  last,
	input  wire logic                  out_free,
	output logic                       idle,
	output pipr_pkg::seq_ctrl_t        ctrl
);

	pipr_pkg::state_t state_q, state_d;
	logic             closing_q, closing_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= pipr_pkg::ST_IDLE;
			closing_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			closing_q <= closing_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		closing_d    = closing_q;
		ctrl.op      = pipr_pkg::OP_HOLD;
		ctrl.closing = closing_q;
		ctrl.decide  = 1'b0;
		ctrl.emit    = 1'b0;
		idle         = 1'b0;
		case (state_q)
			pipr_pkg::ST_IDLE: begin
				idle = 1'b1;
				if (vtx_fire) begin
					// first vertex has no incoming edge; only a lone final one closes
					if (seen) begin
						closing_d = 1'b0;
						state_d   = pipr_pkg::ST_DIFF;
					end else if (final_in) begin
						closing_d = 1'b1;
						state_d   = pipr_pkg::ST_DIFF;
					end
				end
			end
			pipr_pkg::ST_DIFF: begin
				ctrl.op = pipr_pkg::OP_DIFF;
				state_d = pipr_pkg::ST_MUL_AB;
			end
			pipr_pkg::ST_MUL_AB: begin
				ctrl.op = pipr_pkg::OP_MUL_AB;
				state_d = pipr_pkg::ST_MUL_CD;
			end
			pipr_pkg::ST_MUL_CD: begin
				ctrl.op = pipr_pkg::OP_MUL_CD;
				state_d = pipr_pkg::ST_SUB;
			end
			pipr_pkg::ST_SUB: begin
				ctrl.op = pipr_pkg::OP_SUB;
				state_d = pipr_pkg::ST_DECIDE;
			end
			pipr_pkg::ST_DECIDE: begin
				ctrl.decide = 1'b1;
				if (!closing_q && last) begin
					closing_d = 1'b1;
					state_d   = pipr_pkg::ST_DIFF;
				end else if (last) begin
					state_d = pipr_pkg::ST_EMIT;
				end else begin
					state_d = pipr_pkg::ST_IDLE;
				end
			end
			pipr_pkg::ST_EMIT: begin
				if (out_free) begin
					ctrl.emit = 1'b1;
					state_d   = pipr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pipr_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top - point_in_polygon_ray_parity testbench
// Streams polygons corner by corner (directed shapes, then random polygons
// with random gaps and stalls), runs its own crossing-parity predictor on every
// corner transfer and compares each inside flag with the oldest one predicted.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pipr_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int TAIL_CYCLES = 30;
	localparam int CORNER_GOAL = 1450;

	typedef enum {SPREAD_WIDE, SPREAD_LOCAL, SPREAD_EDGE} spread_t;

	typedef struct {
		coord_t qx;
		coord_t qy;
		coord_t cx;
		coord_t cy;
		bit     closes;
		bit     drain;
	} corner_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pipr_vtx_if vtx ();
	pipr_res_if res ();

	point_in_polygon_ray_parity dut (
		.clk    (clk),
		.arst_n (arst_n),
		.vtx    (vtx),
		.res    (res)
	);

	always #2 clk = ~clk;

	corner_item_t corner_queue[$];
	bit           inside_due[$];
	int           corner_total = 0;
	int           corners_taken = 0;
	int           results_owed = 0;
	int           failures = 0;
	int           src_gap = 0;
	int           snk_stall = 0;
	bit           src_calm = 1'b0;
	bit           snk_calm = 1'b0;

	// polygon state of the predictor
	coord_t poly_start_x, poly_start_y, poly_prev_x, poly_prev_y;
	bit     poly_open = 1'b0;
	bit     poly_parity = 1'b0;

	function automatic int sign_of(longint a);
		return (a > 0) - (a < 0);
	endfunction

	// edge c->d against the vertical ray going up from p
	function automatic bit crossing_counts(coord_t px, coord_t py, coord_t cx, coord_t cy,
	                                       coord_t dx, coord_t dy);
		longint ax, ay, bx, by, det;
		if (cx == dx || dx == px)
			return 1'b0;
		ax = longint'(cx) - longint'(px);
		ay = longint'(cy) - longint'(py);
		bx = longint'(dx) - longint'(px);
		by = longint'(dy) - longint'(py);
		if (sign_of(ax) * sign_of(bx) > 0)
			return 1'b0;
		det = ax * by - ay * bx;
		return sign_of(det) * sign_of(longint'(dx) - longint'(cx)) <= 0;
	endfunction

	// returns 1 when the corner closes a polygon; flag then holds the result
	function automatic bit absorb_corner(corner_item_t it, output bit flag);
		flag = 1'b0;
		if (!poly_open) begin
			poly_start_x = it.cx;
			poly_start_y = it.cy;
			poly_parity = 1'b0;
			poly_open = 1'b1;
		end else if (crossing_counts(it.qx, it.qy, poly_prev_x, poly_prev_y, it.cx, it.cy)) begin
			poly_parity = ~poly_parity;
		end
		poly_prev_x = it.cx;
		poly_prev_y = it.cy;
		if (!it.closes)
			return 1'b0;
		if (crossing_counts(it.qx, it.qy, it.cx, it.cy, poly_start_x, poly_start_y))
			poly_parity = ~poly_parity;
		flag = poly_parity;
		poly_open = 1'b0;
		poly_parity = 1'b0;
		return 1'b1;
	endfunction

	// wait length per transfer, with occasional stretches of none
	function automatic int draw_wait(inout bit calm);
		if ($urandom_range(0, 39) == 0)
			calm = ~calm;
		return calm ? 0 : int'($urandom_range(0, 9));
	endfunction

	function automatic coord_t pick_coord(int centre, spread_t spread);
		int v;
		case (spread)
		SPREAD_WIDE: begin
			v = int'($urandom_range(0, 65535)) - 32768;
		end
		SPREAD_LOCAL: begin
			v = centre + int'($urandom_range(0, 200)) - 100;
		end
		default: begin
			case ($urandom_range(0, 4))
			0: v = -32768;
			1: v = 32767;
			2: v = -32767;
			3: v = 32766;
			default: v = 0;
			endcase
		end
		endcase
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return coord_t'(v);
	endfunction

	task automatic add_corner(int qx, int qy, int cx, int cy, bit closes, bit drain);
		corner_item_t it;
		it.qx = coord_t'(qx);
		it.qy = coord_t'(qy);
		it.cx = coord_t'(cx);
		it.cy = coord_t'(cy);
		it.closes = closes;
		it.drain = drain;
		corner_queue.push_back(it);
		corner_total++;
	endtask

	task automatic add_random_polygon(bit drain_first);
		spread_t spread;
		int      n, mid_x, mid_y, pick;
		coord_t  qx, qy, vx, vy, last_x;
		pick = $urandom_range(0, 19);
		spread = (pick < 8) ? SPREAD_WIDE : (pick < 17) ? SPREAD_LOCAL : SPREAD_EDGE;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
		mid_x = int'($urandom_range(0, 65535)) - 32768;
		mid_y = int'($urandom_range(0, 65535)) - 32768;
		qx = pick_coord(mid_x, spread);
		qy = pick_coord(mid_y, spread);
		last_x = '0;
		for (int i = 0; i < n; i++) begin
			vx = pick_coord(mid_x, spread);
			vy = pick_coord(mid_y, spread);
			case ($urandom_range(0, 7))
			0: vx = qx;                    // corner on the ray line
			1: if (i != 0) vx = last_x;    // vertical edge
			default: ;
			endcase
			// now and then the point moves mid-polygon
			if ($urandom_range(0, 19) == 0) begin
				qx = pick_coord(mid_x, spread);
				qy = pick_coord(mid_y, spread);
			end
			add_corner(qx, qy, vx, vy, i == n - 1, drain_first && i == 0);
			last_x = vx;
		end
	endtask

	// corner source
	always @(posedge clk or negedge arst_n) begin : corner_driver
		bit           took;
		corner_item_t nxt;
		if (!arst_n) begin
			vtx.valid <= 1'b0;
			vtx.query_x <= '0;
			vtx.query_y <= '0;
			vtx.corner_x <= '0;
			vtx.corner_y <= '0;
			vtx.final_corner <= 1'b0;
			src_gap = 0;
		end else begin
			took = vtx.valid && vtx.ready;
			if (took)
				src_gap = draw_wait(src_calm);
			if (!vtx.valid || took) begin
				if (src_gap != 0) begin
					src_gap--;
					vtx.valid <= 1'b0;
				end else if (corner_queue.size() != 0 &&
				    (!corner_queue[0].drain || (results_owed == 0 && !took))) begin
					nxt = corner_queue.pop_front();
					vtx.valid <= 1'b1;
					vtx.query_x <= nxt.qx;
					vtx.query_y <= nxt.qy;
					vtx.corner_x <= nxt.cx;
					vtx.corner_y <= nxt.cy;
					vtx.final_corner <= nxt.closes;
				end else begin
					vtx.valid <= 1'b0;
				end
			end
		end
	end

	// result sink
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
			snk_stall = 0;
		end else begin
			if (res.valid && res.ready)
				snk_stall = draw_wait(snk_calm);
			if (snk_stall != 0) begin
				snk_stall--;
				res.ready <= 1'b0;
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	// result check first: no result can stem from a corner taken at the same edge
	always @(posedge clk or negedge arst_n) begin : flag_monitor
		corner_item_t seen;
		bit           inside_now;
		bit           want;
		if (!arst_n) begin
			results_owed <= 0;
			corners_taken <= 0;
		end else begin
			if (res.valid && res.ready) begin
				if (inside_due.size() == 0) begin
					$display("%0t unexpected result: expected none, got inside_res=%0b",
					         $realtime, res.inside_res);
					failures++;
				end else begin
					want = inside_due.pop_front();
					if (res.inside_res !== want) begin
						$display("%0t inside_res mismatch: expected %0b, got %0b",
						         $realtime, want, res.inside_res);
						failures++;
					end
				end
			end
			if (vtx.valid && vtx.ready) begin
				seen.qx = vtx.query_x;
				seen.qy = vtx.query_y;
				seen.cx = vtx.corner_x;
				seen.cy = vtx.corner_y;
				seen.closes = vtx.final_corner;
				seen.drain = 1'b0;
				if (absorb_corner(seen, inside_now))
					inside_due.push_back(inside_now);
				corners_taken <= corners_taken + 1;
			end
			results_owed <= inside_due.size();
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin : watchdog
		int quiet;
		if (!arst_n || (vtx.valid && vtx.ready) || (res.valid && res.ready)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("%0t timeout: no transfer for %0d cycles", $realtime, quiet);
				$display("** point_in_polygon_ray_parity: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		int poly_no;
		vtx.valid = 1'b0;
		vtx.query_x = '0;
		vtx.query_y = '0;
		vtx.corner_x = '0;
		vtx.corner_y = '0;
		vtx.final_corner = 1'b0;
		res.ready = 1'b0;

		// lone corners: degenerate closing edge
		add_corner(32767, -32768, -32768, 32767, 1'b1, 1'b0);
		add_corner(0, 0, 0, 0, 1'b1, 1'b0);
		// square around the point
		add_corner(0, 0, -10, -10, 1'b0, 1'b0);
		add_corner(0, 0, 10, -10, 1'b0, 1'b0);
		add_corner(0, 0, 10, 10, 1'b0, 1'b0);
		add_corner(0, 0, -10, 10, 1'b1, 1'b0);
		// full-range square, sender waits for all flags first
		add_corner(1, 1, -32768, -32768, 1'b0, 1'b1);
		add_corner(1, 1, 32767, -32768, 1'b0, 1'b0);
		add_corner(1, 1, 32767, 32767, 1'b0, 1'b0);
		add_corner(1, 1, -32768, 32767, 1'b1, 1'b0);
		// apex on the ray line
		add_corner(0, 0, 0, 5, 1'b0, 1'b0);
		add_corner(0, 0, 5, -5, 1'b0, 1'b0);
		add_corner(0, 0, -5, -5, 1'b1, 1'b0);
		// point on a vertical edge
		add_corner(10, 0, -10, -10, 1'b0, 1'b0);
		add_corner(10, 0, 10, -10, 1'b0, 1'b0);
		add_corner(10, 0, 10, 10, 1'b0, 1'b0);
		add_corner(10, 0, -10, 10, 1'b1, 1'b0);
		// point moves between corners
		add_corner(0, 0, -100, -100, 1'b0, 1'b0);
		add_corner(500, 500, 100, -100, 1'b0, 1'b0);
		add_corner(-32768, 32767, 0, 100, 1'b1, 1'b0);
		// two-corner polygon
		add_corner(0, 0, 5, -5, 1'b0, 1'b0);
		add_corner(0, 0, -5, 5, 1'b1, 1'b0);

		poly_no = 0;
		while (corner_total < CORNER_GOAL) begin
			add_random_polygon(poly_no % 50 == 49);
			poly_no++;
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (corners_taken != corner_total)
			@(posedge clk);
		while (results_owed != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (results_owed != 0) begin
			$display("%0t %0d inside flags expected but never received",
			         $realtime, results_owed);
			failures += results_owed;
		end
		if (failures == 0) begin
			$display("** point_in_polygon_ray_parity: PASSED **");
		end else begin
			$display("** point_in_polygon_ray_parity: FAILED **");
		end
		$finish;
	end

endmodule
